>>> design/spu_pkg.sv
// ----------------------------------------------------------------------------
// Spark particle update package
// Shared constants, register indexes, the pipeline stage record and a clamp.
// ----------------------------------------------------------------------------
`default_nettype none

package spu_pkg;

    // Pipeline layout: input stage, setup stage, one divider step per stage,
    // then the finishing stages. The last stage is the output register.
    localparam int DivSteps  = 17;
    localparam int DivFirst  = 2;
    localparam int DivLast   = DivFirst + DivSteps - 1;
    localparam int NumStages = DivLast + 5;
    localparam int LastStage = NumStages - 1;

    localparam logic [16:0] One       = 17'h10000;
    localparam logic [15:0] K085      = 16'd55706;
    localparam logic [15:0] K080      = 16'd52429;
    localparam logic [31:0] LifeFloor = 32'd66;

    typedef enum logic [2:0] {
        REG_GRAVITY,
        REG_DAMPING,
        REG_STEP,
        REG_THICKNESS,
        REG_START_COLOR,
        REG_END_COLOR
    } t_reg_idx;

    typedef struct packed {
        logic [31:0]        pos_x;
        logic [31:0]        pos_y;
        logic [31:0]        pos_z;
        logic [32:0]        vx;
        logic [33:0]        vyg;
        logic [32:0]        vz;
        logic [50:0]        prx;
        logic [51:0]        pry;
        logic [50:0]        prz;
        logic [31:0]        vel_x;
        logic [31:0]        vel_y;
        logic [31:0]        vel_z;
        logic [31:0]        nage;
        logic [31:0]        life;
        logic [31:0]        base;
        logic [31:0]        den;
        logic               ovf1;
        logic               ovf2;
        logic [31:0]        rem1;
        logic [31:0]        rem2;
        logic [16:0]        q1;
        logic [16:0]        q2;
        logic [16:0]        t;
        logic [32:0]        m1;
        logic [33:0]        aa;
        logic [16:0]        f;
        logic [15:0]        alpha;
        logic [2:0][34:0]   dc;
        logic [47:0]        tint;
        logic [48:0]        len;
        logic [31:0]        half;
    } t_stage;

    // Clamp a signed value to the signed 32-bit range.
    function automatic logic [31:0] sat_s32(input logic signed [35:0] v);
        logic [31:0] r;
        if (v > 36'sh07FFFFFFF) begin
            r = 32'h7FFFFFFF;
        end else if (v < -36'sh080000000) begin
            r = 32'h80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> design/spark_particle_update.sv
// ----------------------------------------------------------------------------
// Spark particle update
// Moves one spark record forward by one frame: position, damped velocity,
// age, streak half length, tint and opacity.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake                 Carries
//   in       to block   i_in_valid / o_in_ready   one spark record
//   out      from block o_out_valid / i_out_ready updated spark record
//   cfg      to block   i_cfg_valid / o_cfg_ready register index and data
//
// One request enters per cycle while the output is not stalled. The depth
// is set by the two 17-step restoring dividers for the life fraction, one
// quotient bit per stage.
// Reset is synchronous and active low; it empties the pipeline and loads
// the register defaults. Each stage holds while the one after it is full
// and stalled, so a stall at the output backs up without losing requests.
// Gravity times step and the minimum streak length are registered from the
// configuration registers. Gravity is applied in the second stage, so a
// request taken right after a write already sees it.
//
`default_nettype none

module spark_particle_update
    import spu_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    output      logic        o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [47:0] i_cfg_data,
    input  wire logic        i_in_valid,
    output      logic        o_in_ready,
    input  wire logic [31:0] i_pos_x,
    input  wire logic [31:0] i_pos_y,
    input  wire logic [31:0] i_pos_z,
    input  wire logic [31:0] i_vel_x,
    input  wire logic [31:0] i_vel_y,
    input  wire logic [31:0] i_vel_z,
    input  wire logic [31:0] i_age,
    input  wire logic [31:0] i_life,
    input  wire logic [31:0] i_base_len,
    output      logic        o_out_valid,
    input  wire logic        i_out_ready,
    output      logic [31:0] o_new_pos_x,
    output      logic [31:0] o_new_pos_y,
    output      logic [31:0] o_new_pos_z,
    output      logic [31:0] o_new_vel_x,
    output      logic [31:0] o_new_vel_y,
    output      logic [31:0] o_new_vel_z,
    output      logic [31:0] o_new_age,
    output      logic [31:0] o_half_len,
    output      logic [47:0] o_tint,
    output      logic [15:0] o_alpha
);

    // Configuration registers.
    logic [31:0] r_gravity;
    logic [16:0] r_damping;
    logic [16:0] r_step;
    logic [31:0] r_thickness;
    logic [47:0] r_start;
    logic [47:0] r_end;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gravity   <= '0;
            r_damping   <= One;
            r_step      <= 17'd1092;
            r_thickness <= 32'h00010000;
            r_start     <= '1;
            r_end       <= '0;
        end else if (i_cfg_valid) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_GRAVITY:     r_gravity   <= i_cfg_data[31:0];
                REG_DAMPING:     r_damping   <= i_cfg_data[16:0];
                REG_STEP:        r_step      <= i_cfg_data[16:0];
                REG_THICKNESS:   r_thickness <= i_cfg_data[31:0];
                REG_START_COLOR: r_start     <= i_cfg_data;
                REG_END_COLOR:   r_end       <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Derived constants: the per-frame gravity term (floored) and the
    // minimum streak length, 0.8 times the thickness.
    logic signed [49:0] grav_prod;
    logic        [47:0] thick_prod;
    logic signed [33:0] r_g;
    logic        [31:0] r_mn;

    assign grav_prod  = $signed(r_gravity) * $signed({1'b0, r_step});
    assign thick_prod = r_thickness * K080;

    always_ff @(posedge i_clk) begin
        r_g  <= grav_prod[49:16];
        r_mn <= thick_prod[47:16];
    end

    // Pipeline with a valid bit per stage. A stage may load when it is empty
    // or when its contents move on in the same cycle.
    t_stage r_p [NumStages];
    t_stage n_p [NumStages];
    logic   r_v [NumStages];
    logic   rdy [NumStages];

    assign rdy[LastStage] = i_out_ready || !r_v[LastStage];
    assign o_in_ready     = rdy[0];

    genvar k;
    generate
        for (k = 0; k < LastStage; k++) begin : g_rdy
            assign rdy[k] = !r_v[k] || rdy[k+1];
        end

        for (k = 0; k < NumStages; k++) begin : g_stage
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v[k] <= 1'b0;
                end else if (rdy[k]) begin
                    r_v[k] <= (k == 0) ? i_in_valid : r_v[(k == 0) ? 0 : k-1];
                end
            end

            always_ff @(posedge i_clk) begin
                if (rdy[k]) begin
                    r_p[k] <= n_p[k];
                end
            end
        end

        // Input stage: position sums, widened velocities, saturated age.
        always_comb begin
            logic [32:0] age_sum;
            n_p[0]       = '0;
            age_sum      = {1'b0, i_age} + {16'd0, r_step};
            n_p[0].pos_x = i_pos_x + i_vel_x;
            n_p[0].pos_y = i_pos_y + i_vel_y;
            n_p[0].pos_z = i_pos_z + i_vel_z;
            n_p[0].vx    = {i_vel_x[31], i_vel_x};
            n_p[0].vz    = {i_vel_z[31], i_vel_z};
            n_p[0].vyg   = {{2{i_vel_y[31]}}, i_vel_y};
            n_p[0].nage  = age_sum[32] ? 32'hFFFFFFFF : age_sum[31:0];
            n_p[0].life  = i_life;
            n_p[0].base  = i_base_len;
        end

        // Setup stage: gravity on y, damping products for x and z and the
        // divider start. The quotients saturate when the age is at least
        // twice the divisor, which also keeps the first partial remainder
        // below the divisor.
        always_comb begin
            n_p[1]      = r_p[0];
            n_p[1].vyg  = r_p[0].vyg - r_g;
            n_p[1].prx  = $signed(r_p[0].vx) * $signed({1'b0, r_damping});
            n_p[1].prz  = $signed(r_p[0].vz) * $signed({1'b0, r_damping});
            n_p[1].den  = (r_p[0].life > LifeFloor) ? r_p[0].life : LifeFloor;
            n_p[1].ovf1 = {1'b0, r_p[0].nage} >=
                          {((r_p[0].life > LifeFloor) ? r_p[0].life : LifeFloor), 1'b0};
            n_p[1].ovf2 = {1'b0, r_p[0].nage} >= {r_p[0].life, 1'b0};
            n_p[1].rem1 = {1'b0, r_p[0].nage[31:1]};
            n_p[1].rem2 = {1'b0, r_p[0].nage[31:1]};
            n_p[1].q1   = '0;
            n_p[1].q2   = '0;
        end

        // Divider steps: one quotient bit for each of the two divisions.
        // The y damping product and the velocity clamps ride along in the
        // first two of them.
        for (k = DivFirst; k <= DivLast; k++) begin : g_div
            localparam int Qb = DivLast - k;
            always_comb begin
                logic        nb;
                logic [32:0] sh1;
                logic [32:0] sh2;
                n_p[k] = r_p[k-1];
                nb     = (k == DivFirst) ? r_p[k-1].nage[0] : 1'b0;
                sh1    = {r_p[k-1].rem1, nb};
                sh2    = {r_p[k-1].rem2, nb};
                if (sh1 >= {1'b0, r_p[k-1].den}) begin
                    n_p[k].rem1   = 32'(sh1 - {1'b0, r_p[k-1].den});
                    n_p[k].q1[Qb] = 1'b1;
                end else begin
                    n_p[k].rem1 = sh1[31:0];
                end
                if (sh2 >= {1'b0, r_p[k-1].life}) begin
                    n_p[k].rem2   = 32'(sh2 - {1'b0, r_p[k-1].life});
                    n_p[k].q2[Qb] = 1'b1;
                end else begin
                    n_p[k].rem2 = sh2[31:0];
                end
                if (k == DivFirst) begin
                    n_p[k].pry   = $signed(r_p[k-1].vyg) * $signed({1'b0, r_damping});
                    n_p[k].vel_x = sat_s32({r_p[k-1].prx[50], r_p[k-1].prx[50:16]});
                    n_p[k].vel_z = sat_s32({r_p[k-1].prz[50], r_p[k-1].prz[50:16]});
                end
                if (k == DivFirst + 1) begin
                    n_p[k].vel_y = sat_s32(r_p[k-1].pry[51:16]);
                end
            end
        end
    endgenerate

    // Clamp the fractions and form the two products that depend on them.
    always_comb begin
        logic [16:0] ta;
        logic [16:0] a;
        n_p[DivLast+1]   = r_p[DivLast];
        n_p[DivLast+1].t = (r_p[DivLast].ovf1 || r_p[DivLast].q1 > One) ?
                           One : r_p[DivLast].q1;
        ta = (r_p[DivLast].ovf2 || r_p[DivLast].q2 > One) ? One : r_p[DivLast].q2;
        a  = One - ta;
        n_p[DivLast+1].m1 = n_p[DivLast+1].t * K085;
        n_p[DivLast+1].aa = {17'd0, a} * {17'd0, a};
    end

    // Streak factor, opacity and color differences scaled by t.
    always_comb begin
        n_p[DivLast+2]   = r_p[DivLast+1];
        n_p[DivLast+2].f = One - r_p[DivLast+1].m1[32:16];
        if (r_p[DivLast+1].life == '0) begin
            n_p[DivLast+2].alpha = '0;
        end else if (r_p[DivLast+1].aa[33:16] > 18'h0FFFF) begin
            n_p[DivLast+2].alpha = 16'hFFFF;
        end else begin
            n_p[DivLast+2].alpha = r_p[DivLast+1].aa[31:16];
        end
        for (int c = 0; c < 3; c++) begin
            n_p[DivLast+2].dc[c] =
                $signed({1'b0, r_end[16*c +: 16]} - {1'b0, r_start[16*c +: 16]}) *
                $signed({1'b0, r_p[DivLast+1].t});
        end
    end

    // Streak length product and final color channels.
    always_comb begin
        n_p[DivLast+3]     = r_p[DivLast+2];
        n_p[DivLast+3].len = r_p[DivLast+2].base * r_p[DivLast+2].f;
        for (int c = 0; c < 3; c++) begin
            n_p[DivLast+3].tint[16*c +: 16] =
                r_start[16*c +: 16] + r_p[DivLast+2].dc[c][31:16];
        end
    end

    // Output stage: larger of streak and minimum length, halved.
    always_comb begin
        logic [32:0] lens;
        logic [32:0] pick;
        n_p[LastStage]      = r_p[LastStage-1];
        lens                = r_p[LastStage-1].len[48:16];
        pick                = (lens > {1'b0, r_mn}) ? lens : {1'b0, r_mn};
        n_p[LastStage].half = pick[32:1];
    end

    assign o_out_valid = r_v[LastStage];
    assign o_new_pos_x = r_p[LastStage].pos_x;
    assign o_new_pos_y = r_p[LastStage].pos_y;
    assign o_new_pos_z = r_p[LastStage].pos_z;
    assign o_new_vel_x = r_p[LastStage].vel_x;
    assign o_new_vel_y = r_p[LastStage].vel_y;
    assign o_new_vel_z = r_p[LastStage].vel_z;
    assign o_new_age   = r_p[LastStage].nage;
    assign o_half_len  = r_p[LastStage].half;
    assign o_tint      = r_p[LastStage].tint;
    assign o_alpha     = r_p[LastStage].alpha;

endmodule

`default_nettype wire

>>> design/spu_checker.sv
// ----------------------------------------------------------------------------
// Spark particle update checker
// Port-level checks of the pipeline's handshake behavior.
// ----------------------------------------------------------------------------
`default_nettype none

module spu_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_in_ready,
    input wire logic        o_out_valid,
    input wire logic        i_out_ready,
    input wire logic [31:0] o_new_age,
    input wire logic [15:0] o_alpha
);

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result shown right after reset");

    // With nothing waiting at the output every stage can move.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled while output is empty");

    // A stalled result stays valid, with its age and opacity unchanged.
    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_new_age) && $stable(o_alpha))
        else $error("stalled result changed");

endmodule

bind spark_particle_update spu_checker u_spu_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_new_age   (o_new_age),
    .o_alpha     (o_alpha)
);

`default_nettype wire
